@@ hw/rtl/classifier_vote_smoother_core_defines.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef CLASSIFIER_VOTE_SMOOTHER_CORE_DEFINES_SVH
`define CLASSIFIER_VOTE_SMOOTHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cvs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cvs: next-cycle check failed");

`endif

@@ hw/rtl/cvs_pkg.sv @@
`timescale 1ns / 1ps

package cvs_pkg;

    // Field widths.
    localparam int PIXELS_W = 11;
    localparam int CLASS_W  = 3;
    localparam int CONF_W   = 16;
    localparam int VOTES_W  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACTIVITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONFIDENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOTES      = 2'd2;

    localparam logic [PIXELS_W-1:0] ACTIVITY_THR_RST   = 11'd20;
    localparam logic [CONF_W-1:0]   CONFIDENCE_THR_RST = 16'd26214;  // about 0.40 in Q0.16
    localparam logic [VOTES_W-1:0]  VOTE_THR_RST       = 4'd5;

    // Stream payload widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Width used when comparing class indexes against class counts.
    localparam int CIDX_CMP_W = 5;

    typedef struct packed {
        logic [PIXELS_W-1:0] active_pixels;
        logic [CLASS_W-1:0]  predicted_class;
        logic [CONF_W-1:0]   class_confidence;
        logic                inference_ok;
    } cvs_item_t;

    typedef struct packed {
        logic                class_valid;
        logic [CLASS_W-1:0]  stable_class;
        logic [VOTES_W-1:0]  top_votes;
    } cvs_vote_t;

endpackage

@@ hw/rtl/classifier_vote_smoother_core.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Beat contents
// ---------+-----+-----------------------------------------------------------
// s_       | in  | one frame's classifier result (pixels, class, confidence, ok)
// m_       | out | one stabilized class decision per input beat
// cfg_     | in  | register write: 0 activity, 1 confidence, 2 vote threshold
//
// Every accepted input beat yields exactly one output beat, presented on m_
// once it has passed the stages below. While m_tready does not stall, the
// block takes one beat every cycle: an input register, the window update, and
// the vote register each hold one item, and the vote of one item is formed
// while the next updates the window.
// Reset (aresetn low, synchronous) empties the window, restores the register
// defaults and drops any beats in flight. A stall on m_tready holds the output
// beat; earlier stages still fill any gaps, then s_tready falls.

`include "classifier_vote_smoother_core_defines.svh"

module classifier_vote_smoother_core import cvs_pkg::*; #(
    parameter int WINDOW_LEN  = 10,
    parameter int NUM_CLASSES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [10:0] active_pixels, [13:11] predicted_class, [29:14] class_confidence,
    // [31:30] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] inference_ok
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] stable_class, [6:3] top_votes, [7] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] class_valid
    output logic                  m_tuser,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TallyW = $clog2(WINDOW_LEN + 1);

    // Configuration registers.
    logic [PIXELS_W-1:0] act_thr_reg;
    logic [CONF_W-1:0]   conf_thr_reg;
    logic [VOTES_W-1:0]  vote_thr_reg;

    // Pipeline registers.
    logic       in_valid_reg;
    cvs_item_t  in_item_reg;
    logic       vote_valid_reg;
    logic       out_valid_reg;
    cvs_vote_t  out_reg;

    logic       out_load;
    logic       win_ready;
    logic       advance;
    logic       s_accept;

    logic [TallyW-1:0] tally [NUM_CLASSES];
    cvs_vote_t         vote;

    // The output register frees when it is empty or its beat is taken; each
    // earlier stage moves when the stage after it can take its item.
    assign out_load  = !out_valid_reg || m_tready;
    assign win_ready = !vote_valid_reg || out_load;
    assign advance   = in_valid_reg && win_ready;
    assign s_tready  = !in_valid_reg || win_ready;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_thr_reg  <= ACTIVITY_THR_RST;
            conf_thr_reg <= CONFIDENCE_THR_RST;
            vote_thr_reg <= VOTE_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_ACTIVITY:   act_thr_reg  <= cfg_wdata[PIXELS_W-1:0];
                CFG_IDX_CONFIDENCE: conf_thr_reg <= cfg_wdata[CONF_W-1:0];
                CFG_IDX_VOTES:      vote_thr_reg <= cfg_wdata[VOTES_W-1:0];
                default: ;  // Unknown registers are ignored.
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            vote_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (win_ready) begin
                vote_valid_reg <= in_valid_reg;
            end
            if (out_load) begin
                out_valid_reg <= vote_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.active_pixels    <= s_tdata[10:0];
            in_item_reg.predicted_class  <= s_tdata[13:11];
            in_item_reg.class_confidence <= s_tdata[29:14];
            in_item_reg.inference_ok     <= s_tuser;
        end
        if (out_load && vote_valid_reg) begin
            out_reg <= vote;
        end
    end

    // The window and tallies advance with the item leaving the input register.
    cvs_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance_i  (advance),
        .item_i     (in_item_reg),
        .act_thr_i  (act_thr_reg),
        .conf_thr_i (conf_thr_reg),
        .tally_o    (tally)
    );

    // The tallies hold the state left by the item in the vote stage; the
    // next item cannot touch them until that vote has been registered.
    cvs_vote #(
        .WINDOW_LEN  (WINDOW_LEN),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_vote (
        .tally_i    (tally),
        .vote_thr_i (vote_thr_reg),
        .vote_o     (vote)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.top_votes, out_reg.stable_class};
    assign m_tuser  = out_reg.class_valid;

    // An output beat without a class carries class index zero.
    `CVS_ASSERT_IMPL(a_none_zero_class, aclk, aresetn,
        m_tvalid && !m_tuser, m_tdata[2:0] == '0)

    // If WINDOW_LEN < 16, a valid class has >= 1 vote and meets the threshold.
    `CVS_ASSERT_IMPL(a_valid_meets_thr, aclk, aresetn,
        m_tvalid && m_tuser && (WINDOW_LEN < 16),
        (m_tdata[6:3] != '0) && (m_tdata[6:3] >= vote_thr_reg))

    // An item in the vote stage that cannot leave is still there next cycle.
    `CVS_ASSERT_NEXT(a_vote_held, aclk, aresetn,
        vote_valid_reg && !out_load, vote_valid_reg)

endmodule

@@ hw/rtl/cvs_window.sv @@
`timescale 1ns / 1ps

// Sliding vote window: ring buffer of class entries plus per-class tallies,
// updated by each advancing item that is quiet or carries inference_ok.
module cvs_window import cvs_pkg::*; #(
    parameter int WINDOW_LEN  = 10,
    parameter int NUM_CLASSES = 8,
    localparam int TallyW     = $clog2(WINDOW_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance_i,
    input  cvs_item_t           item_i,
    input  logic [PIXELS_W-1:0] act_thr_i,
    input  logic [CONF_W-1:0]   conf_thr_i,
    output logic [TallyW-1:0]   tally_o [NUM_CLASSES]
);

    localparam int PtrW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SumW = TallyW + 1;

    logic [CLASS_W-1:0] win_cls_reg [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] win_vld_reg, win_vld_next;
    logic [PtrW-1:0]    head_reg, head_next;
    logic [TallyW-1:0]  fill_reg, fill_next;
    logic [TallyW-1:0]  tally_reg [NUM_CLASSES];
    logic [TallyW-1:0]  tally_next [NUM_CLASSES];

    logic               quiet;
    logic               do_push;
    logic               cls_ok;
    logic               has_class;
    logic               full;
    logic [CLASS_W-1:0] old_cls;
    logic               drop_vote;
    logic [SumW-1:0]    slot_sum;
    logic [SumW-1:0]    slot_wrap;
    logic [PtrW-1:0]    slot;
    logic [PtrW:0]      head_inc;
    logic [PtrW-1:0]    head_adv;
    logic               cls_we;
    logic               inc_k;
    logic               dec_k;

    always_comb begin
        quiet     = item_i.active_pixels <= act_thr_i;
        do_push   = quiet || item_i.inference_ok;
        cls_ok    = CIDX_CMP_W'(item_i.predicted_class) < CIDX_CMP_W'(NUM_CLASSES);
        has_class = !quiet && cls_ok && (item_i.class_confidence >= conf_thr_i);
        full      = fill_reg == TallyW'(WINDOW_LEN);
        old_cls   = win_cls_reg[head_reg];
        drop_vote = full && win_vld_reg[head_reg];

        // Head plus fill stays below twice the window length.
        slot_sum  = SumW'(head_reg) + SumW'(fill_reg);
        slot_wrap = (slot_sum >= SumW'(WINDOW_LEN)) ? slot_sum - SumW'(WINDOW_LEN)
                                                    : slot_sum;
        slot      = full ? head_reg : slot_wrap[PtrW-1:0];

        head_inc  = (PtrW + 1)'(head_reg) + (PtrW + 1)'(1);
        head_adv  = (head_inc == (PtrW + 1)'(WINDOW_LEN)) ? '0 : head_inc[PtrW-1:0];

        cls_we       = advance_i && do_push && !quiet && has_class;
        win_vld_next = win_vld_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        tally_next   = tally_reg;
        inc_k        = 1'b0;
        dec_k        = 1'b0;

        if (advance_i && do_push) begin
            if (quiet) begin
                // A quiet frame empties the window and leaves one "none" entry.
                win_vld_next = '0;
                head_next    = '0;
                fill_next    = TallyW'(1);
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    tally_next[k] = '0;
                end
            end else begin
                if (full) begin
                    win_vld_next[head_reg] = 1'b0;
                    head_next              = head_adv;
                end else begin
                    fill_next = fill_reg + TallyW'(1);
                end
                win_vld_next[slot] = has_class;
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    dec_k = drop_vote && (CIDX_CMP_W'(old_cls) == CIDX_CMP_W'(k));
                    inc_k = has_class &&
                            (CIDX_CMP_W'(item_i.predicted_class) == CIDX_CMP_W'(k));
                    tally_next[k] = tally_reg[k] + TallyW'(inc_k) - TallyW'(dec_k);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_vld_reg <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                tally_reg[k] <= '0;
            end
        end else begin
            win_vld_reg <= win_vld_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            tally_reg   <= tally_next;
        end
    end

    // Class entries are only read where their valid bit is set.
    always_ff @(posedge aclk) begin
        if (cls_we) begin
            win_cls_reg[slot] <= item_i.predicted_class;
        end
    end

    assign tally_o = tally_reg;

endmodule

@@ hw/rtl/cvs_vote.sv @@
`timescale 1ns / 1ps

// Picks the class with the most votes; the lowest index wins ties.
module cvs_vote import cvs_pkg::*; #(
    parameter int WINDOW_LEN  = 10,
    parameter int NUM_CLASSES = 8,
    localparam int TallyW     = $clog2(WINDOW_LEN + 1)
) (
    input  logic [TallyW-1:0]  tally_i [NUM_CLASSES],
    input  logic [VOTES_W-1:0] vote_thr_i,
    output cvs_vote_t          vote_o
);

    logic [TallyW-1:0]     best;
    logic [CIDX_CMP_W-1:0] best_idx;
    logic                  valid;

    always_comb begin
        best     = '0;
        best_idx = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (tally_i[k] > best) begin
                best     = tally_i[k];
                best_idx = CIDX_CMP_W'(k);
            end
        end
        valid = (best != '0) && (8'(best) >= 8'(vote_thr_i));

        vote_o.class_valid  = valid;
        vote_o.stable_class = valid ? best_idx[CLASS_W-1:0] : '0;
        vote_o.top_votes    = VOTES_W'(best);
    end

endmodule
